@@ src/bsr_pkg.sv @@
// Shared definitions for the fixed-point square root block: widths, register
// indexes, the divider control struct and the microcode program table.
// Depends on nothing; every other file imports it.
package bsr_pkg;

   localparam int DATA_WIDTH      = 32;
   localparam int FRAC_BITS       = 16;
   localparam int MAG_WIDTH       = DATA_WIDTH - 1;
   localparam int DIVIDEND_WIDTH  = DATA_WIDTH + FRAC_BITS;
   localparam int DIV_CNT_WIDTH   = $clog2(DIVIDEND_WIDTH);
   localparam int TOL_WIDTH       = 17;
   localparam int LIMIT_WIDTH     = 6;
   localparam int ITER_WIDTH      = 6;
   localparam int CSR_DATA_WIDTH  = 17;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int PC_WIDTH        = 3;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TOLERANCE  = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ITER_LIMIT = 1'd1;

   localparam logic [TOL_WIDTH-1:0]   TOL_RESET   = 17'd16;
   localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 6'd40;

   // Program step addresses.
   localparam logic [PC_WIDTH-1:0] STEP_IDLE      = 3'd0;
   localparam logic [PC_WIDTH-1:0] STEP_CHECK     = 3'd1;
   localparam logic [PC_WIDTH-1:0] STEP_DIV_INIT  = 3'd2;
   localparam logic [PC_WIDTH-1:0] STEP_DIV_STEP  = 3'd3;
   localparam logic [PC_WIDTH-1:0] STEP_UPDATE    = 3'd4;
   localparam logic [PC_WIDTH-1:0] STEP_TEST      = 3'd5;
   localparam logic [PC_WIDTH-1:0] STEP_EMIT      = 3'd6;
   localparam logic [PC_WIDTH-1:0] STEP_EMIT_BAD  = 3'd7;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_LOAD,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_UPDATE,
      OP_EMIT,
      OP_EMIT_INVALID
   } op_type;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NO_START,
      COND_INVALID,
      COND_DIV_MORE,
      COND_NOT_DONE
   } cond_type;

   typedef struct packed {
      op_type                op;
      cond_type              cond;
      logic [PC_WIDTH-1:0]   target;
   } ucode_type;

   typedef struct packed {
      logic init;
      logic step;
   } div_ctrl_type;

   // The program: a jump is taken when its condition holds, else the step
   // counter advances by one.
   function automatic ucode_type ucode_rom(input logic [PC_WIDTH-1:0] pc);
      ucode_type word;
      unique case (pc)
         STEP_IDLE:     word = '{OP_LOAD,         COND_NO_START, STEP_IDLE};
         STEP_CHECK:    word = '{OP_NONE,         COND_INVALID,  STEP_EMIT_BAD};
         STEP_DIV_INIT: word = '{OP_DIV_INIT,     COND_NEVER,    STEP_IDLE};
         STEP_DIV_STEP: word = '{OP_DIV_STEP,     COND_DIV_MORE, STEP_DIV_STEP};
         STEP_UPDATE:   word = '{OP_UPDATE,       COND_NEVER,    STEP_IDLE};
         STEP_TEST:     word = '{OP_NONE,         COND_NOT_DONE, STEP_DIV_INIT};
         STEP_EMIT:     word = '{OP_EMIT,         COND_ALWAYS,   STEP_IDLE};
         STEP_EMIT_BAD: word = '{OP_EMIT_INVALID, COND_ALWAYS,   STEP_IDLE};
         default:       word = '{OP_NONE,         COND_ALWAYS,   STEP_IDLE};
      endcase
      return word;
   endfunction

endpackage

@@ src/bsr_divider.sv @@
// Restoring fixed-point divider, one quotient bit per step, saturating.
// Depends on bsr_pkg for widths and the divider control struct.
module bsr_divider
   import bsr_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  div_ctrl_type              ctrl,
   input  logic [DIVIDEND_WIDTH-1:0] dividend,
   input  logic [MAG_WIDTH-1:0]      divisor,
   output logic [MAG_WIDTH-1:0]      quotient,
   output logic                      more
);

   logic [DIVIDEND_WIDTH-1:0] num_ff, num_in;
   logic [MAG_WIDTH-1:0]      rem_ff, rem_in;
   logic [MAG_WIDTH-1:0]      quo_ff, quo_in;
   logic                      sat_ff, sat_in;
   logic [DIV_CNT_WIDTH-1:0]  cnt_ff, cnt_in;
   logic [MAG_WIDTH:0]        trial;
   logic                      fits;

   assign trial = {rem_ff, num_ff[DIVIDEND_WIDTH-1]};
   assign fits  = trial >= {1'b0, divisor};

   always_comb begin
      num_in = num_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      sat_in = sat_ff;
      cnt_in = cnt_ff;
      if (ctrl.init) begin
         num_in = dividend;
         rem_in = '0;
         quo_in = '0;
         sat_in = 1'b0;
         cnt_in = DIV_CNT_WIDTH'(DIVIDEND_WIDTH - 1);
      end else if (ctrl.step) begin
         num_in = {num_ff[DIVIDEND_WIDTH-2:0], 1'b0};
         // The remainder stays below the divisor, so it fits MAG_WIDTH bits.
         rem_in = fits ? MAG_WIDTH'(trial - {1'b0, divisor}) : trial[MAG_WIDTH-1:0];
         // A set top bit about to be shifted out means the quotient overflows.
         sat_in = sat_ff | quo_ff[MAG_WIDTH-1];
         quo_in = {quo_ff[MAG_WIDTH-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      sat_ff <= sat_in;
   end

   assign quotient = sat_ff ? {MAG_WIDTH{1'b1}} : quo_ff;
   assign more     = cnt_ff != '0;

endmodule

@@ src/babylonian_square_root.sv @@
// Top level of the fixed-point Babylonian square root block: microcode
// sequencer, datapath, configuration registers and result register.
// Depends on bsr_pkg and bsr_divider.
//
//   Channel   Ports                                   Transfer
//   --------  --------------------------------------  ------------------------------
//   request   start, busy, req_radicand,              edge with start high, busy low
//             req_start_guess
//   response  rsp_strobe, rsp_root, rsp_invalid,      every edge ending a strobe cycle
//             rsp_capped, rsp_iterations
//   config    csr_write_enable, csr_index,            every edge with write enable
//             csr_write_data
//
// An invalid request goes from the check step to the invalid-emit step, which
// registers its result. A valid request runs, for each update, a step that arms
// the divider, the bit-serial divider itself, a step that updates the estimate
// and a step that tests it, with the check and emit steps around that loop.
// Reset is synchronous and returns the sequencer to its idle step and the
// registers to tolerance 16 and limit 40.
// The receiver cannot stall: each result is strobed for exactly one cycle.
module babylonian_square_root
   import bsr_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic signed [DATA_WIDTH-1:0] req_radicand,
   input  logic signed [DATA_WIDTH-1:0] req_start_guess,
   output logic                       rsp_strobe,
   output logic [MAG_WIDTH-1:0]       rsp_root,
   output logic                       rsp_invalid,
   output logic                       rsp_capped,
   output logic [ITER_WIDTH-1:0]      rsp_iterations,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data
);

   // Sequencer state: the step counter and the control word it selects.
   logic [PC_WIDTH-1:0] pc_ff, pc_in;
   ucode_type           uword;
   logic                jump;

   // Configuration registers.
   logic [TOL_WIDTH-1:0]   tol_ff, tol_in;
   logic [LIMIT_WIDTH-1:0] limit_ff, limit_in;

   // Datapath registers.
   logic [DATA_WIDTH-1:0] s_ff, s_in;
   logic                  bad_ff, bad_in;
   logic [MAG_WIDTH-1:0]  x_ff, x_in;
   logic [MAG_WIDTH-1:0]  x_prev_ff, x_prev_in;
   logic [ITER_WIDTH-1:0] iter_ff, iter_in;

   // Result register.
   logic                  rsp_strobe_ff, rsp_strobe_in;
   logic [MAG_WIDTH-1:0]  rsp_root_ff, rsp_root_in;
   logic                  rsp_invalid_ff, rsp_invalid_in;
   logic                  rsp_capped_ff, rsp_capped_in;
   logic [ITER_WIDTH-1:0] rsp_iter_ff, rsp_iter_in;

   // Divider interface.
   div_ctrl_type          div_ctrl;
   logic [MAG_WIDTH-1:0]  quotient;
   logic                  div_more;

   // Update and convergence terms.
   logic [DATA_WIDTH-1:0]  sum;
   logic [MAG_WIDTH-1:0]   diff;
   logic                   converged;
   logic [LIMIT_WIDTH-1:0] limit_eff;
   logic                   hit_limit;
   logic                   not_done;
   logic                   accept;

   assign uword  = ucode_rom(pc_ff);
   assign busy   = pc_ff != STEP_IDLE;
   assign accept = start && !busy;

   assign div_ctrl.init = uword.op == OP_DIV_INIT;
   assign div_ctrl.step = uword.op == OP_DIV_STEP;

   bsr_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .dividend ({s_ff, {FRAC_BITS{1'b0}}}),
      .divisor  (x_ff),
      .quotient (quotient),
      .more     (div_more)
   );

   // The estimate and the quotient both stay below 2^31, so their sum needs
   // one extra bit and the halving brings it back to the magnitude width.
   assign sum  = {1'b0, x_ff} + {1'b0, quotient};
   assign diff = (x_ff > x_prev_ff) ? (x_ff - x_prev_ff) : (x_prev_ff - x_ff);

   // An estimate that has fallen to zero stops the run as converged, which
   // also keeps the divider from ever seeing a zero divisor.
   assign converged = (diff <= {{(MAG_WIDTH - TOL_WIDTH){1'b0}}, tol_ff}) || (x_ff == '0);

   // A limit of zero behaves as one, since at least one update always runs.
   assign limit_eff = (limit_ff == '0) ? LIMIT_WIDTH'(1) : limit_ff;
   assign hit_limit = iter_ff >= limit_eff;
   assign not_done  = !converged && !hit_limit;

   always_comb begin
      case (uword.cond)
         COND_NEVER:    jump = 1'b0;
         COND_ALWAYS:   jump = 1'b1;
         COND_NO_START: jump = !start;
         COND_INVALID:  jump = bad_ff;
         COND_DIV_MORE: jump = div_more;
         COND_NOT_DONE: jump = not_done;
         default:       jump = 1'b1;
      endcase
      pc_in = jump ? uword.target : pc_ff + 1'b1;
   end

   // Configuration writes; an index past the list has no register to land in.
   always_comb begin
      tol_in   = tol_ff;
      limit_in = limit_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_TOLERANCE:  tol_in   = csr_write_data[TOL_WIDTH-1:0];
            CSR_ITER_LIMIT: limit_in = csr_write_data[LIMIT_WIDTH-1:0];
            default:        tol_in   = tol_ff;
         endcase
      end
   end

   // Datapath operations selected by the control word.
   always_comb begin
      s_in           = s_ff;
      bad_in         = bad_ff;
      x_in           = x_ff;
      x_prev_in      = x_prev_ff;
      iter_in        = iter_ff;
      rsp_strobe_in  = 1'b0;
      rsp_root_in    = rsp_root_ff;
      rsp_invalid_in = rsp_invalid_ff;
      rsp_capped_in  = rsp_capped_ff;
      rsp_iter_in    = rsp_iter_ff;
      unique case (uword.op)
         OP_LOAD: begin
            // Loaded on every idle cycle; only the value present at the
            // transfer is kept, because the step counter then moves on.
            s_in    = req_radicand;
            x_in    = req_start_guess[MAG_WIDTH-1:0];
            iter_in = '0;
            bad_in  = req_radicand[DATA_WIDTH-1] || req_start_guess[DATA_WIDTH-1]
                      || (req_start_guess == '0);
         end
         OP_UPDATE: begin
            x_prev_in = x_ff;
            x_in      = sum[DATA_WIDTH-1:1];
            iter_in   = iter_ff + 1'b1;
         end
         OP_EMIT: begin
            rsp_strobe_in  = 1'b1;
            rsp_root_in    = x_ff;
            rsp_invalid_in = 1'b0;
            rsp_capped_in  = !converged;
            rsp_iter_in    = iter_ff;
         end
         OP_EMIT_INVALID: begin
            rsp_strobe_in  = 1'b1;
            rsp_root_in    = '0;
            rsp_invalid_in = 1'b1;
            rsp_capped_in  = 1'b0;
            rsp_iter_in    = '0;
         end
         default: begin
            s_in = s_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff         <= STEP_IDLE;
         tol_ff        <= TOL_RESET;
         limit_ff      <= LIMIT_RESET;
         rsp_strobe_ff <= 1'b0;
      end else begin
         pc_ff         <= pc_in;
         tol_ff        <= tol_in;
         limit_ff      <= limit_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      s_ff           <= s_in;
      bad_ff         <= bad_in;
      x_ff           <= x_in;
      x_prev_ff      <= x_prev_in;
      iter_ff        <= iter_in;
      rsp_root_ff    <= rsp_root_in;
      rsp_invalid_ff <= rsp_invalid_in;
      rsp_capped_ff  <= rsp_capped_in;
      rsp_iter_ff    <= rsp_iter_in;
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_root       = rsp_root_ff;
   assign rsp_invalid    = rsp_invalid_ff;
   assign rsp_capped     = rsp_capped_ff;
   assign rsp_iterations = rsp_iter_ff;

   // A result is always followed by at least one quiet cycle, since the
   // sequencer returns to its idle step after emitting.
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for two cycles");

   // A transfer always moves the sequencer out of its idle step.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("request transfer did not start the sequencer");

   // Invalid operands clear every other result field.
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_invalid |-> (rsp_root == '0) && !rsp_capped
                                    && (rsp_iterations == '0))
      else $error("invalid result carries nonzero fields");

   // A valid run always performs at least one update.
   a_valid_iter: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_invalid |-> rsp_iterations != '0)
      else $error("valid result reports zero updates");

endmodule
